// ===== rtl/interval_overlap_segment_table_top_macros.svh =====
// assertion macros for the segment table
`ifndef INTERVAL_OVERLAP_SEGMENT_TABLE_TOP_MACROS_SVH
`define INTERVAL_OVERLAP_SEGMENT_TABLE_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define IOST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define IOST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/iost_pkg.sv =====
// ---------------------------------------------------------------------------
// iost_pkg
// constants and codes of the interval overlap segment table
// ---------------------------------------------------------------------------
package iost_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_VALUE_BITS   = 16;
  localparam int DEF_COUNT_BITS   = 7;
  localparam int THR_BITS         = 7;
  localparam int OP_BITS          = 2;
  localparam int STATUS_BITS      = 2;

  // none-found sentinels, 100.0 and -100.0 in q8.8
  localparam int NONE_LOW_Q  = 25600;
  localparam int NONE_HIGH_Q = -25600;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT    = 2'd0,
    OP_MAX_QUERY = 2'd1,
    OP_THR_QUERY = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

endpackage

// ===== rtl/iost_ram.sv =====
// ---------------------------------------------------------------------------
// iost_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module iost_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/interval_overlap_segment_table_top.sv =====
// insert: a table scan, then each stored segment is fetched, loaded and split into
//   pieces, plus the leading and trailing pieces
// most-overlapped query: two table scans; threshold query: one table scan
// every request then passes through the result register
// one request at a time, set by the single ram read port that walks the table
// synchronous reset empties the table at once; no clearing pass
// ---------------------------------------------------------------------------
// interval_overlap_segment_table_top
// sorted gap-free segment table with overlap counts, insert and range queries
// ---------------------------------------------------------------------------
module interval_overlap_segment_table_top
  import iost_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int VALUE_BITS   = DEF_VALUE_BITS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS,
  localparam int IN_W        = 2 * VALUE_BITS + THR_BITS,
  localparam int IN_DW       = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = 2 * VALUE_BITS + COUNT_BITS,
  localparam int OUT_DW      = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DW-1:0]       s_tdata,   // range_low, range_high, threshold
  input  logic [OP_BITS-1:0]     s_tuser,   // op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DW-1:0]      m_tdata,   // result_low, result_high, best_count
  output logic [STATUS_BITS-1:0] m_tuser    // status
);

  localparam int VB   = VALUE_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int EW   = 2 * VB + CB;
  localparam int KW   = $clog2(MAX_SEGMENTS);
  localparam int TW   = $clog2(MAX_SEGMENTS + 1);
  localparam int CW   = (CB > THR_BITS) ? CB : THR_BITS;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam logic [31:0] NL32 = 32'(NONE_LOW_Q);
  localparam logic [31:0] NH32 = 32'(NONE_HIGH_Q);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_UNION = 9'b000000100,
    S_PRE   = 9'b000001000,
    S_FETCH = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_SPLIT = 9'b001000000,
    S_POST  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  function automatic logic [EW-1:0] mk(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                       input logic [CB-1:0] c);
    mk = {c, b, a};
  endfunction

  state_t state;
  logic bank;
  logic [TW-1:0] total, k, pidx_s, wr_k;
  logic rd_pend;
  logic [OP_BITS-1:0] op_r;
  logic signed [VB-1:0] lo_r, hi_r, first_lo, last_hi, rlo, rhi, cur_lo, ent_hi;
  logic [THR_BITS-1:0] thr_r;
  logic [CB-1:0] best, ent_cnt;
  logic in_lo, in_hi, found;
  logic [STATUS_BITS-1:0] status_r;
  logic [EW-1:0] p0, p1, q0, q1;
  logic [1:0] pcnt, pidx, qcnt, qidx;

  logic ram_we;
  logic [KW:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, rdata;

  logic signed [VB-1:0] ea, eb, in_lo_v, in_hi_v, cut;
  logic [CB-1:0] ec, piece_cnt;
  logic sel, scan_done;
  logic [1:0] need;
  logic [TW:0] need_sum;
  logic [TW-1:0] k_inc;

  logic m_valid_r;
  logic [OUT_W-1:0] m_data_r;
  logic [STATUS_BITS-1:0] m_user_r;

  iost_ram #(.WIDTH(EW), .DEPTH(2 * MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign ea = rdata[VB-1:0];
  assign eb = rdata[2*VB-1:VB];
  assign ec = rdata[EW-1:2*VB];
  assign in_lo_v = s_tdata[VB-1:0];
  assign in_hi_v = s_tdata[2*VB-1:VB];
  assign k_inc = k + 1'b1;
  assign scan_done = (k == total) && !rd_pend;
  assign ram_raddr = {bank, k[KW-1:0]};
  assign ram_waddr = {~bank, wr_k[KW-1:0]};
  assign s_tready = (state == S_IDLE);

  // segment chosen for the union
  assign sel = (state == S_UNION) ? (ec == best) : (CW'(ec) > CW'(thr_r));

  // next split point of the segment being copied
  always_comb begin
    if (lo_r > cur_lo && lo_r < ent_hi) begin
      cut = lo_r;
    end else if (hi_r > cur_lo && hi_r < ent_hi) begin
      cut = hi_r;
    end else begin
      cut = ent_hi;
    end
    piece_cnt = ent_cnt;
    if (cur_lo >= lo_r && cut <= hi_r && ent_cnt < CMAX) begin
      piece_cnt = ent_cnt + 1'b1;
    end
  end

  // extra entries an insert needs
  always_comb begin
    if (total == '0) begin
      need = 2'd1;
    end else if (lo_r >= last_hi || hi_r <= first_lo) begin
      need = (lo_r > last_hi || hi_r < first_lo) ? 2'd2 : 2'd1;
    end else begin
      need = 2'((lo_r < first_lo || in_lo) ? 1 : 0) + 2'((hi_r > last_hi || in_hi) ? 1 : 0);
    end
    need_sum = {1'b0, total} + (TW + 1)'(need);
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = mk(cur_lo, cut, piece_cnt);
    unique case (state)
      S_PRE: begin
        ram_we = (pidx < pcnt);
        ram_wdata = (pidx == 2'd0) ? p0 : p1;
      end
      S_SPLIT: begin
        ram_we = 1'b1;
      end
      S_POST: begin
        ram_we = (qidx < qcnt);
        ram_wdata = (qidx == 2'd0) ? q0 : q1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank <= 1'b0;
      total <= '0;
      k <= '0;
      rd_pend <= 1'b0;
      wr_k <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r <= s_tuser;
            lo_r <= in_lo_v;
            hi_r <= in_hi_v;
            thr_r <= s_tdata[2*VB+THR_BITS-1:2*VB];
            k <= '0;
            rd_pend <= 1'b0;
            best <= '0;
            found <= 1'b0;
            rlo <= '0;
            rhi <= '0;
            in_lo <= 1'b0;
            in_hi <= 1'b0;
            status_r <= ST_OK;
            priority if (s_tuser == OP_INSERT && in_lo_v >= in_hi_v) begin
              status_r <= ST_BAD;
              state <= S_FIN;
            end else if (s_tuser == OP_INSERT || s_tuser == OP_MAX_QUERY ||
                         s_tuser == OP_THR_QUERY) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN, S_UNION: begin
          rd_pend <= (k != total);
          if (k != total) begin
            pidx_s <= k;
            k <= k_inc;
          end
          if (rd_pend) begin
            if (pidx_s == '0) begin
              first_lo <= ea;
            end
            if (pidx_s == total - 1'b1) begin
              last_hi <= eb;
            end
            if (ea < lo_r && lo_r < eb) begin
              in_lo <= 1'b1;
            end
            if (ea < hi_r && hi_r < eb) begin
              in_hi <= 1'b1;
            end
            if (state == S_SCAN && op_r == OP_MAX_QUERY && ec > best) begin
              best <= ec;
            end
            if (sel && (state == S_UNION || op_r == OP_THR_QUERY)) begin
              if (!found || ea < rlo) begin
                rlo <= ea;
              end
              if (!found || eb > rhi) begin
                rhi <= eb;
              end
              found <= 1'b1;
            end
          end
          if (scan_done) begin
            k <= '0;
            if (state == S_UNION) begin
              state <= S_FIN;
            end else begin
              unique case (op_r)
                OP_MAX_QUERY: begin
                  if (total == '0) begin
                    status_r <= ST_NONE;
                    state <= S_FIN;
                  end else begin
                    state <= S_UNION;
                  end
                end
                OP_THR_QUERY: begin
                  if (!found) begin
                    status_r <= ST_NONE;
                    rlo <= NL32[VB-1:0];
                    rhi <= NH32[VB-1:0];
                  end
                  state <= S_FIN;
                end
                default: begin
                  pidx <= 2'd0;
                  qidx <= 2'd0;
                  wr_k <= '0;
                  pcnt <= 2'd0;
                  qcnt <= 2'd0;
                  p0 <= mk(lo_r, hi_r, CB'(1));
                  p1 <= mk(hi_r, first_lo, '0);
                  q0 <= mk(last_hi, hi_r, CB'(1));
                  q1 <= mk(lo_r, hi_r, CB'(1));
                  priority if (total == '0) begin
                    pcnt <= 2'd1;
                  end else if (lo_r >= last_hi) begin
                    if (lo_r > last_hi) begin
                      q0 <= mk(last_hi, lo_r, '0);
                      qcnt <= 2'd2;
                    end else begin
                      q0 <= mk(lo_r, hi_r, CB'(1));
                      qcnt <= 2'd1;
                    end
                  end else if (hi_r <= first_lo) begin
                    pcnt <= (hi_r < first_lo) ? 2'd2 : 2'd1;
                  end else begin
                    p0 <= mk(lo_r, first_lo, CB'(1));
                    pcnt <= (lo_r < first_lo) ? 2'd1 : 2'd0;
                    qcnt <= (hi_r > last_hi) ? 2'd1 : 2'd0;
                  end
                  if (need_sum > (TW + 1)'(MAX_SEGMENTS)) begin
                    status_r <= ST_FULL;
                    state <= S_FIN;
                  end else begin
                    state <= S_PRE;
                  end
                end
              endcase
            end
          end
        end
        S_PRE: begin
          if (pidx < pcnt) begin
            pidx <= pidx + 1'b1;
            wr_k <= wr_k + 1'b1;
          end else if (total == '0) begin
            state <= S_POST;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          cur_lo <= ea;
          ent_hi <= eb;
          ent_cnt <= ec;
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          wr_k <= wr_k + 1'b1;
          cur_lo <= cut;
          if (cut == ent_hi) begin
            k <= k_inc;
            state <= (k_inc < total) ? S_FETCH : S_POST;
          end
        end
        S_POST: begin
          if (qidx < qcnt) begin
            qidx <= qidx + 1'b1;
            wr_k <= wr_k + 1'b1;
          end else begin
            total <= wr_k;
            bank <= ~bank;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_valid_r || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid_r <= 1'b0;
    end else if (state == S_FIN && (!m_valid_r || m_tready)) begin
      m_valid_r <= 1'b1;
      m_data_r <= {best, rhi, rlo};
      m_user_r <= status_r;
    end else if (m_tready) begin
      m_valid_r <= 1'b0;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_W-1:0] = m_data_r;
  end

  assign m_tvalid = m_valid_r;
  assign m_tuser = m_user_r;

`include "interval_overlap_segment_table_top_macros.svh"

  `IOST_ASSERT(a_total_bound, total <= TW'(MAX_SEGMENTS), "segment total beyond table size")
  `IOST_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
  `IOST_ASSERT(a_write_in_range, ram_we |-> (wr_k < TW'(MAX_SEGMENTS)), "table write past end")

endmodule
